// File: rtl/core/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    // Pool geometry. The pool size must be a power of two.
    localparam int POOL_UNITS = 1024;
    localparam int POOL_LOG   = $clog2(POOL_UNITS);
    localparam int ADDR_W     = POOL_LOG + 1;
    localparam int TREE_SLOTS = 2 ** ADDR_W;

    // Field widths of the stream payloads.
    localparam int REQ_W     = 11;
    localparam int TAG_W     = 8;
    localparam int OFF_W     = 10;
    localparam int SIZE_W    = 11;
    localparam int WASTE_W   = 9;
    localparam int RES_W     = 1 + OFF_W + SIZE_W + WASTE_W;
    localparam int S_TDATA_W = ((REQ_W + TAG_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    // Level counters must hold the tree height and the log of any request.
    localparam int LOG_MAX = (POOL_LOG > REQ_W) ? POOL_LOG : REQ_W;
    localparam int LVL_W   = $clog2(LOG_MAX + 2);

    typedef logic [1:0] node_st_t;
    localparam node_st_t ST_FREE  = 2'd0;
    localparam node_st_t ST_SPLIT = 2'd1;
    localparam node_st_t ST_USED  = 2'd2;

    typedef enum logic [1:0] {
        MV_HOLD,
        MV_ROOT,
        MV_DOWN,
        MV_SKIP
    } move_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_FREE,
        WR_SPLIT,
        WR_USED
    } wr_t;

    typedef struct packed {
        logic  load_in;
        logic  clr_step;
        move_t move;
        wr_t   wr;
        logic  load_out;
        logic  out_ok;
    } dp_cmd_t;

    typedef struct packed {
        logic     clr_last;
        logic     too_big;
        node_st_t node_st;
        logic     at_need;
        logic     skip_end;
    } dp_stat_t;

    // Ceiling log2 of a nonzero request: the bit length of (r - 1).
    function automatic logic [LVL_W-1:0] need_log_f(input logic [REQ_W-1:0] r);
        logic [REQ_W-1:0] m;
        logic [LVL_W-1:0] res;
        m   = r - REQ_W'(1);
        res = '0;
        for (int i = 0; i < REQ_W; i++) begin
            if (m[i]) begin
                res = LVL_W'(i + 1);
            end
        end
        return res;
    endfunction

    // Number of trailing zeros; the lowest set bit wins.
    function automatic logic [LVL_W-1:0] tz_f(input logic [ADDR_W:0] v);
        logic [LVL_W-1:0] res;
        res = '0;
        for (int i = ADDR_W; i >= 0; i--) begin
            if (v[i]) begin
                res = LVL_W'(i);
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/core/buddy_block_allocator_core.sv
`timescale 1ns / 1ps

// Buddy allocator over a pool of POOL_UNITS units (1024), kept as a binary tree
// of node states (free, split, allocated) in a node-state memory with one read
// port and one write port. Each request transfer carries a size and an owner tag;
// the size is rounded up to a power of two, a zero size counts as one unit, and a
// size above the pool fails at once. The tree is searched depth first, left before
// right, and the first free block of a fitting size is granted; a larger free
// block is split down its left edge. One result transfer follows every request:
// granted, block offset, block size and waste, or all zeros on failure. Blocks are
// never freed.
// After reset the block sweeps all 2048 entries of the node-state memory to free,
// one entry a cycle, with s_tready low. A request visits tree nodes one per cycle,
// as the state memory gives one node read per cycle, and then splits each level
// below the chosen free block. An output register holds the result, so a new
// request is accepted while the last result still waits on m_tready.

module buddy_block_allocator_core import bba_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: request_size [10:0], owner_tag [18:11], zero fill [23:19]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // m_tdata: granted [0], block_offset [10:1], block_size [21:11],
    // waste [30:22], zero fill [31]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller sequences the clearing sweep, the search and the split
    // walk; it owns the handshakes and the result valid flag.
    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the request, the current tree position, the node
    // memories and the result register.
    bba_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

    logic [OFF_W-1:0]  mon_off;
    logic [SIZE_W-1:0] mon_size;

    assign mon_off  = m_tdata[OFF_W:1];
    assign mon_size = m_tdata[OFF_W+SIZE_W:OFF_W+1];

    // While reset is held the clearing sweep restarts, so no request is taken.
    a_no_accept_in_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request accepted right after reset");

    // A granted block has a nonzero size that fits in the pool.
    a_grant_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (mon_size != '0 && 32'(mon_size) <= POOL_UNITS))
        else $error("granted block size out of range");

    // A granted block starts on a multiple of its own size.
    a_grant_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> ((32'(mon_off) & (32'(mon_size) - 32'd1)) == 32'd0))
        else $error("granted block not aligned to its size");

    // A failed request reports all fields as zero.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata == '0))
        else $error("failed request carries nonzero fields");

endmodule

// File: rtl/core/bba_ctrl.sv
`timescale 1ns / 1ps

module bba_ctrl import bba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_MARK   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   ok_reg, ok_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        ok_next      = ok_reg;
        cmd          = '0;
        cmd.move     = MV_HOLD;
        cmd.wr       = WR_NONE;

        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                cmd.wr       = WR_FREE;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    if (stat.too_big) begin
                        ok_next    = 1'b0;
                        state_next = S_FINISH;
                    end else begin
                        cmd.move   = MV_ROOT;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (stat.node_st == ST_FREE) begin
                    if (stat.at_need) begin
                        cmd.wr     = WR_USED;
                        ok_next    = 1'b1;
                        state_next = S_FINISH;
                    end else begin
                        cmd.wr     = WR_SPLIT;
                        cmd.move   = MV_DOWN;
                        state_next = S_MARK;
                    end
                end else if (stat.node_st == ST_SPLIT && !stat.at_need) begin
                    cmd.move = MV_DOWN;
                end else if (stat.skip_end) begin
                    ok_next    = 1'b0;
                    state_next = S_FINISH;
                end else begin
                    cmd.move = MV_SKIP;
                end
            end
            S_MARK: begin
                if (stat.at_need) begin
                    cmd.wr     = WR_USED;
                    ok_next    = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    cmd.wr   = WR_SPLIT;
                    cmd.move = MV_DOWN;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    cmd.out_ok   = ok_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ok_reg      <= ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// File: rtl/core/bba_dpath.sv
`timescale 1ns / 1ps

module bba_dpath import bba_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [REQ_W-1:0]     in_req;
    logic [TAG_W-1:0]     in_tag;
    logic [REQ_W-1:0]     in_eff;

    logic [REQ_W-1:0]     req_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [LVL_W-1:0]     need_log_reg;
    logic [ADDR_W-1:0]    cur_reg, cur_next;
    logic [LVL_W-1:0]     level_reg, level_next;
    logic [ADDR_W-1:0]    clr_reg;
    node_st_t             rd_st_reg;
    logic [M_TDATA_W-1:0] out_reg;

    logic [ADDR_W:0]      inc;
    logic [LVL_W-1:0]     tz;
    logic [ADDR_W:0]      skip_full;

    logic                 st_we;
    logic [ADDR_W-1:0]    st_wa;
    node_st_t             st_wd;

    logic [ADDR_W-1:0]    off_full;
    logic [RES_W-1:0]     res_word;

    node_st_t             st_mem   [TREE_SLOTS];
    logic [TAG_W+REQ_W-1:0] info_mem [TREE_SLOTS];

    // Input fields: a zero request counts as one unit.
    assign in_req = s_tdata[REQ_W-1:0];
    assign in_tag = s_tdata[REQ_W +: TAG_W];
    assign in_eff = (in_req == '0) ? REQ_W'(1) : in_req;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            req_reg      <= in_eff;
            tag_reg      <= in_tag;
            need_log_reg <= need_log_f(in_eff);
        end
    end

    // Next node after a rejected one: strip the trailing ones and step right.
    assign inc       = {1'b0, cur_reg} + (ADDR_W + 1)'(1);
    assign tz        = tz_f(inc);
    assign skip_full = inc >> tz;

    always_comb begin
        case (cmd.move)
            MV_ROOT: begin
                cur_next   = ADDR_W'(1);
                level_next = LVL_W'(POOL_LOG);
            end
            MV_DOWN: begin
                cur_next   = {cur_reg[ADDR_W-2:0], 1'b0};
                level_next = level_reg - LVL_W'(1);
            end
            MV_SKIP: begin
                cur_next   = skip_full[ADDR_W-1:0];
                level_next = level_reg + tz;
            end
            default: begin
                cur_next   = cur_reg;
                level_next = level_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        level_reg <= level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + ADDR_W'(1);
        end
    end

    // Node-state memory: one write and one registered read per cycle.
    // The read always follows the node that becomes current next cycle.
    always_comb begin
        st_we = (cmd.wr != WR_NONE);
        st_wa = (cmd.wr == WR_FREE) ? clr_reg : cur_reg;
        case (cmd.wr)
            WR_SPLIT: st_wd = ST_SPLIT;
            WR_USED:  st_wd = ST_USED;
            default:  st_wd = ST_FREE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[st_wa] <= st_wd;
        end
        rd_st_reg <= st_mem[cur_next];
    end

    // Owner tag and effective request of each granted block.
    always_ff @(posedge aclk) begin
        if (cmd.wr == WR_USED) begin
            info_mem[cur_reg] <= {tag_reg, req_reg};
        end
    end

    // The granted node shifted by its level gives pool size plus offset.
    assign off_full = ADDR_W'(cur_reg << need_log_reg);

    always_comb begin
        res_word = '0;
        if (cmd.out_ok) begin
            res_word[0]                        = 1'b1;
            res_word[OFF_W:1]                  = OFF_W'(off_full[POOL_LOG-1:0]);
            res_word[OFF_W+SIZE_W:OFF_W+1]     = SIZE_W'(32'd1 << need_log_reg);
            res_word[RES_W-1:OFF_W+SIZE_W+1]   =
                WASTE_W'((32'd1 << need_log_reg) - 32'(req_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= M_TDATA_W'(res_word);
        end
    end

    assign stat.clr_last = &clr_reg;
    assign stat.too_big  = (32'(in_eff) > POOL_UNITS);
    assign stat.node_st  = rd_st_reg;
    assign stat.at_need  = (level_reg == need_log_reg);
    assign stat.skip_end = (skip_full == (ADDR_W + 1)'(1));

    assign m_tdata = out_reg;

endmodule

// File: sim/buddy_block_allocator_core_tb.sv
`timescale 1ns / 1ps

import bba_pkg::*;

// One result transfer, unpacked from m_tdata.
typedef struct packed {
    logic               granted;
    logic [OFF_W-1:0]   offset;
    logic [SIZE_W-1:0]  size;
    logic [WASTE_W-1:0] waste;
} grant_t;

// Keeps its own copy of the node tree and the queue of grants still due.
class alloc_scoreboard;
    node_st_t tree_st [TREE_SLOTS];
    grant_t   due [$];
    int       errors;

    function new();
        foreach (tree_st[i]) tree_st[i] = ST_FREE;
        errors = 0;
    endfunction

    task report(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Depth-first search, left child before right, splitting free nodes on the
    // way down. An explicit stack stands in for recursion.
    function grant_t place_block(logic [REQ_W-1:0] req_raw);
        grant_t res;
        int     eff;
        int     need;
        int     node;
        int     span;
        int     off;
        int     node_q [$];
        int     span_q [$];
        int     off_q [$];
        res = '0;
        eff = (req_raw == '0) ? 1 : int'(req_raw);
        if (eff > POOL_UNITS) return res;
        need = 1;
        while (need < eff) need = need * 2;
        node_q.push_back(1);
        span_q.push_back(POOL_UNITS);
        off_q.push_back(0);
        while (node_q.size() > 0) begin
            node = node_q.pop_back();
            span = span_q.pop_back();
            off  = off_q.pop_back();
            if (node >= TREE_SLOTS || span < need || tree_st[node] == ST_USED) continue;
            if (tree_st[node] == ST_FREE) begin
                if (span == need) begin
                    tree_st[node] = ST_USED;
                    res.granted = 1'b1;
                    res.offset  = OFF_W'(off);
                    res.size    = SIZE_W'(need);
                    res.waste   = WASTE_W'(need - eff);
                    return res;
                end
                tree_st[node] = ST_SPLIT;
                if (2 * node + 1 < TREE_SLOTS) begin
                    tree_st[2 * node]     = ST_FREE;
                    tree_st[2 * node + 1] = ST_FREE;
                end
            end
            // A split node of exactly the needed size is never granted whole.
            if (span < 2 || span == need) continue;
            node_q.push_back(2 * node + 1);
            span_q.push_back(span / 2);
            off_q.push_back(off + span / 2);
            node_q.push_back(2 * node);
            span_q.push_back(span / 2);
            off_q.push_back(off);
        end
        return res;
    endfunction

    function void note_request(logic [S_TDATA_W-1:0] word);
        due.push_back(place_block(word[REQ_W-1:0]));
    endfunction

    task check_grant(logic [M_TDATA_W-1:0] word);
        grant_t want;
        grant_t got;
        if (due.size() == 0) begin
            report($sformatf("result transfer %h with no request pending", word));
            return;
        end
        want = due.pop_front();
        got.granted = word[0];
        got.offset  = word[OFF_W:1];
        got.size    = word[OFF_W+SIZE_W:OFF_W+1];
        got.waste   = word[RES_W-1:OFF_W+SIZE_W+1];
        if (got.granted !== want.granted)
            report($sformatf("granted %0d, want %0d", got.granted, want.granted));
        if (got.offset !== want.offset)
            report($sformatf("block_offset %0d, want %0d", got.offset, want.offset));
        if (got.size !== want.size)
            report($sformatf("block_size %0d, want %0d", got.size, want.size));
        if (got.waste !== want.waste)
            report($sformatf("waste %0d, want %0d", got.waste, want.waste));
        if (word[M_TDATA_W-1:RES_W] !== '0)
            report($sformatf("fill bits of result transfer not zero: %h", word));
    endtask
endclass

module buddy_block_allocator_core_tb;

    localparam int IDLE_LIMIT   = 10000;
    localparam int RANDOM_ITEMS = 268;
    localparam int TAIL_CYCLES  = 20;

    logic                 aclk;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready;

    alloc_scoreboard ledger;
    bit              calm;
    int              idle_cycles = 0;

    buddy_block_allocator_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one, none while calm is set.
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Small requests dominate so that the pool fills slowly and fragments.
    function automatic logic [REQ_W-1:0] random_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return REQ_W'($urandom_range(0, 2));
        if (pick < 85) return REQ_W'($urandom_range(3, 8));
        if (pick < 94) return REQ_W'($urandom_range(9, 32));
        if (pick < 96) return REQ_W'($urandom_range(33, 128));
        if (pick < 98) return REQ_W'($urandom_range(129, 1024));
        return REQ_W'($urandom_range(1025, 2047));
    endfunction

    // Called and returning at a falling edge.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [TAG_W-1:0] tag);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({tag, req});
        do @(posedge aclk); while (!s_tready);
        ledger.note_request(s_tdata);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (ledger.due.size() != 0);
    endtask

    // Receiver side: one ready cycle, then a random stall.
    initial begin
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ledger.check_grant(m_tdata);
    end

    // Ends the run when no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n;
        ledger      = new();
        calm        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Oversized requests fail, zero counts as one unit, and the whole
        // pool is refused once the root has been split.
        send_request(11'd2047, 8'hFF);
        send_request(11'd1025, 8'h5A);
        send_request(11'd0,    8'h00);
        send_request(11'd1024, 8'hA5);
        send_request(11'd1,    8'h01);
        send_request(11'd3,    8'h33);
        send_request(11'd2,    8'h02);
        send_request(11'd5,    8'h55);
        send_request(11'd513,  8'hC3);
        send_request(11'd9,    8'h09);
        send_request(11'd17,   8'h11);
        send_request(11'd7,    8'h77);
        send_request(11'd8,    8'h80);
        send_request(11'd6,    8'h66);
        send_request(11'd4,    8'h44);
        send_request(11'd0,    8'hFE);
        send_request(11'd129,  8'h81);
        send_request(11'd1026, 8'h7F);
        send_request(11'd16,   8'h10);
        send_request(11'd33,   8'h21);
        send_request(11'd64,   8'h40);
        send_request(11'd2,    8'h20);
        wait_drained();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 29) == 0) calm = !calm;
            if (n == RANDOM_ITEMS / 2) wait_drained();
            send_request(random_size(), TAG_W'($urandom_range(0, 255)));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (ledger.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
